// ===== rtl/kpcf_pkg.sv =====
package kpcf_pkg;

  localparam int PREFIX_LEN = 4;
  localparam int NUM_BYTES  = 6;
  localparam int MSG_BYTES  = 2 * NUM_BYTES;
  localparam int IDLE_W     = 17;
  localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

  localparam logic [3:0] NUM_KEYS = 4'd12;
  localparam logic [3:0] KEY_STAR = 4'd9;

  typedef logic [7:0] byte_t;

  typedef enum logic {
    ACT_KEY  = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef enum logic {
    KIND_BEEP  = 1'b0,
    KIND_FRAME = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_MIN_LEN = 2'd1,
    REG_MAX_LEN = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [3:0]  min_len;
    logic [3:0]  max_len;
  } cfg_t;

  // One command for the back end: up to two frames, then an optional beep.
  typedef struct packed {
    logic [1:0]                 nfr;
    logic [1:0]                 total;
    logic [3:0]                 n0;
    logic [3:0]                 n1;
    logic                       beep;
    logic [NUM_BYTES-1:0][7:0]  fr0;
    logic [NUM_BYTES-1:0][7:0]  fr1;
  } cmd_t;

  typedef struct packed {
    logic                       kind;
    logic [1:0]                 seq;
    logic [1:0]                 total;
    logic [3:0]                 flen;
    logic [NUM_BYTES-1:0][7:0]  bytes;
    logic                       last;
  } res_t;

  function automatic byte_t key_char(logic [3:0] k);
    byte_t c;
    case (k)
      4'd0:    c = "1";
      4'd1:    c = "2";
      4'd2:    c = "3";
      4'd3:    c = "4";
      4'd4:    c = "5";
      4'd5:    c = "6";
      4'd6:    c = "7";
      4'd7:    c = "8";
      4'd8:    c = "9";
      4'd9:    c = "*";
      4'd10:   c = "0";
      4'd11:   c = "#";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic byte_t prefix_char(logic [1:0] j);
    byte_t c;
    case (j)
      2'd0:    c = "P";
      2'd1:    c = "I";
      2'd2:    c = "N";
      default: c = ":";
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/kpcf_front.sv =====
module kpcf_front #(
  parameter int MAX_DIGITS        = 8,
  parameter int PAYLOAD_PER_FRAME = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          action,
  input  logic [3:0]    key_index,
  input  kpcf_pkg::cfg_t cfg,
  output logic          cmd_push,
  output kpcf_pkg::cmd_t cmd
);
  import kpcf_pkg::*;

  localparam int CW    = $clog2(MAX_DIGITS + 1);
  localparam int IW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int LW    = $clog2(MAX_DIGITS + PREFIX_LEN + 1);
  localparam int CMPW  = (CW > 4) ? CW : 4;
  localparam int PW    = $clog2(PAYLOAD_PER_FRAME + 1);
  localparam int F0    = (PREFIX_LEN + PAYLOAD_PER_FRAME - 1) / PAYLOAD_PER_FRAME;
  localparam int FILL0 = PREFIX_LEN - (F0 - 1) * PAYLOAD_PER_FRAME;

  logic [CW-1:0]     count;
  logic [IDLE_W-1:0] idle;
  logic [1:0]        frames;
  logic [PW-1:0]     fill;
  byte_t             store [MAX_DIGITS];

  logic              is_tick, key_ok, is_star, append, done, send;
  logic [IW-1:0]     wp;
  byte_t             ch;
  logic [CW-1:0]     count_app;
  logic [1:0]        frames_app;
  logic [PW-1:0]     fill_app;
  logic [IDLE_W-1:0] idle_inc;
  logic [LW-1:0]     len, len_rest;
  logic [MSG_BYTES-1:0][7:0] msg;

  assign is_tick = (action == ACT_TICK);
  assign key_ok  = (key_index < NUM_KEYS);
  assign is_star = (key_index == KEY_STAR);
  assign ch      = key_char(key_index);
  assign wp      = count[IW-1:0];
  assign append  = accept && !is_tick && key_ok && !is_star &&
                   (count < CW'(MAX_DIGITS));

  // The frame count and the fill of the last frame follow each appended digit.
  always_comb begin
    count_app  = count;
    frames_app = frames;
    fill_app   = fill;
    if (append) begin
      count_app = count + CW'(1);
      if (fill == PW'(PAYLOAD_PER_FRAME)) begin
        frames_app = frames + 2'd1;
        fill_app   = PW'(1);
      end else begin
        fill_app = fill + PW'(1);
      end
    end
  end

  assign idle_inc = (idle == IDLE_MAX) ? idle : idle + IDLE_W'(1);

  always_comb begin
    if (is_tick) begin
      done = accept && (idle_inc > IDLE_W'(cfg.timeout_ms));
    end else begin
      done = accept && key_ok &&
             (is_star || (CMPW'(count_app) >= CMPW'(cfg.max_len)) ||
              (count_app >= CW'(MAX_DIGITS)));
    end
  end

  assign send     = (CMPW'(count_app) >= CMPW'(cfg.min_len));
  assign len      = LW'(count_app) + LW'(PREFIX_LEN);
  assign len_rest = len - LW'(PAYLOAD_PER_FRAME);

  // Message image: the prefix, then the stored digits with the new one bypassed in.
  always_comb begin
    for (int j = 0; j < MSG_BYTES; j++) begin
      if (j < PREFIX_LEN) begin
        msg[j] = prefix_char(2'(j));
      end else if (j - PREFIX_LEN < MAX_DIGITS) begin
        if (append && (IW'(j - PREFIX_LEN) == wp)) begin
          msg[j] = ch;
        end else begin
          msg[j] = store[IW'(j - PREFIX_LEN)];
        end
      end else begin
        msg[j] = 8'd0;
      end
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.beep  = !is_tick;
    cmd.total = frames_app;
    if (done && send) begin
      cmd.nfr = (len > LW'(PAYLOAD_PER_FRAME)) ? 2'd2 : 2'd1;
    end
    cmd.n0 = (len > LW'(PAYLOAD_PER_FRAME)) ? 4'(PAYLOAD_PER_FRAME) : 4'(len);
    cmd.n1 = (len_rest > LW'(PAYLOAD_PER_FRAME)) ? 4'(PAYLOAD_PER_FRAME) : 4'(len_rest);
    for (int k = 0; k < NUM_BYTES; k++) begin
      if (k < PAYLOAD_PER_FRAME) begin
        cmd.fr0[k] = msg[k];
        cmd.fr1[k] = msg[PAYLOAD_PER_FRAME + k];
      end
    end
  end

  assign cmd_push = is_tick ? (done && send) : (accept && key_ok);

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      idle   <= '0;
      frames <= 2'(F0);
      fill   <= PW'(FILL0);
    end else if (accept && (is_tick || key_ok)) begin
      idle <= is_tick ? idle_inc : '0;
      if (done) begin
        count  <= '0;
        frames <= 2'(F0);
        fill   <= PW'(FILL0);
      end else begin
        count  <= count_app;
        frames <= frames_app;
        fill   <= fill_app;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (append) begin
      store[wp] <= ch;
    end
  end

endmodule

// ===== rtl/kpcf_cmd_fifo.sv =====
module kpcf_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  kpcf_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output kpcf_pkg::cmd_t dout,
  output logic           empty
);
  import kpcf_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ===== rtl/kpcf_back.sv =====
module kpcf_back (
  input  logic           clk,
  input  logic           rst,
  input  kpcf_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  output kpcf_pkg::res_t res_out,
  output logic           res_valid,
  input  logic           res_pop
);
  import kpcf_pkg::*;

  logic [1:0]                step;
  logic                      load, is_frame;
  logic [3:0]                n;
  logic [NUM_BYTES-1:0][7:0] fr;
  res_t                      res;

  assign load     = cmd_valid && (!res_valid || res_pop);
  assign is_frame = (step < cmd.nfr);
  assign fr       = step[0] ? cmd.fr1 : cmd.fr0;
  assign n        = step[0] ? cmd.n1 : cmd.n0;

  always_comb begin
    res = '0;
    if (is_frame) begin
      res.kind  = KIND_FRAME;
      res.seq   = step + 2'd1;
      res.total = cmd.total;
      res.flen  = n + 4'd2;
      for (int k = 0; k < NUM_BYTES; k++) begin
        res.bytes[k] = (4'(k) < n) ? fr[k] : 8'd0;
      end
      res.last = (step == cmd.nfr - 2'd1) && !cmd.beep;
    end else begin
      res.kind = KIND_BEEP;
      res.last = 1'b1;
    end
  end

  assign cmd_pop = load && res.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 2'd0;
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
      step      <= res.last ? 2'd0 : step + 2'd1;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res;
    end
  end

endmodule

// ===== rtl/keypad_pin_collector_framer.sv =====
// Channel   Direction  Handshake            Payload
// input     in         push / full          action, key_index
// result    out        pop / empty          kind, seq, total, frame_len, byte0..byte5, last
// config    in         wr_en (no wait)      wr_index, wr_data
//
// An input request is taken while full is low; the front end updates the PIN state
// and queues one command for the back end when the request causes results.
// The back end sends one result per cycle from the output register while the
// receiver keeps popping, so a request there yields its frames, then any beep.
// A two-entry command queue lets the front end keep taking requests while the
// result side is stalled; full rises only when that queue holds two commands.
// Reset clears the PIN, the idle counter and the queue, empties the output register,
// and loads the register defaults (timeout 5000 ms, minimum 5, maximum 8).
module keypad_pin_collector_framer #(
  parameter int MAX_DIGITS        = 8,
  parameter int PAYLOAD_PER_FRAME = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        action,
  input  logic [3:0]  key_index,
  output logic        empty,
  input  logic        pop,
  output logic        kind,
  output logic [1:0]  seq,
  output logic [1:0]  total,
  output logic [3:0]  frame_len,
  output logic [7:0]  byte0,
  output logic [7:0]  byte1,
  output logic [7:0]  byte2,
  output logic [7:0]  byte3,
  output logic [7:0]  byte4,
  output logic [7:0]  byte5,
  output logic        last,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data
);
  import kpcf_pkg::*;

  cfg_t cfg;
  logic accept;
  logic cmd_push, fifo_full, fifo_empty, cmd_pop, res_valid;
  cmd_t cmd_in, cmd_head;
  res_t res;

  // Configuration registers. Writes to an index past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ms <= 16'd5000;
      cfg.min_len    <= 4'd5;
      cfg.max_len    <= 4'd8;
    end else if (wr_en) begin
      case (wr_index)
        REG_TIMEOUT: cfg.timeout_ms <= wr_data;
        REG_MIN_LEN: cfg.min_len    <= wr_data[3:0];
        REG_MAX_LEN: cfg.max_len    <= wr_data[3:0];
        default: ;
      endcase
    end
  end

  // A request is taken whenever the command queue has room, even if this
  // particular request turns out to need no command.
  assign full   = fifo_full;
  assign accept = push && !fifo_full;

  kpcf_front #(
    .MAX_DIGITS        (MAX_DIGITS),
    .PAYLOAD_PER_FRAME (PAYLOAD_PER_FRAME)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .action    (action),
    .key_index (key_index),
    .cfg       (cfg),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  kpcf_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (fifo_full),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .empty (fifo_empty)
  );

  kpcf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_head),
    .cmd_valid (!fifo_empty),
    .cmd_pop   (cmd_pop),
    .res_out   (res),
    .res_valid (res_valid),
    .res_pop   (pop)
  );

  // The output register drives the result ports directly.
  assign empty     = !res_valid;
  assign kind      = res.kind;
  assign seq       = res.seq;
  assign total     = res.total;
  assign frame_len = res.flen;
  assign byte0     = res.bytes[0];
  assign byte1     = res.bytes[1];
  assign byte2     = res.bytes[2];
  assign byte3     = res.bytes[3];
  assign byte4     = res.bytes[4];
  assign byte5     = res.bytes[5];
  assign last      = res.last;

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !fifo_full)
    else $error("command queued while the queue is full");

  a_beep_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_BEEP) |-> last)
    else $error("beep result not marked last");

  a_frame_len_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_FRAME) |->
      (frame_len >= 4'd3 && frame_len <= 4'(PAYLOAD_PER_FRAME + 2)))
    else $error("frame length out of range");

  a_pop_only_from_queue: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !fifo_empty)
    else $error("command popped from an empty queue");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kpcf_pkg::*;

  // Store size and frame payload as built into the block.
  localparam int MAX_DIGITS  = 8;
  localparam int FRAME_BYTES = 6;
  // Cycles the block may still be busy after the last result it owes us.
  localparam int SETTLE      = 10;
  // Hard stop for a hung run.
  localparam int CYCLE_LIMIT = 100000;

  // One request as the keypad side offers it.
  typedef struct packed {
    action_t    act;
    logic [3:0] key;
  } pad_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        action = 1'b0;
  logic [3:0]  key_index = 4'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic        kind;
  logic [1:0]  seq;
  logic [1:0]  total;
  logic [3:0]  frame_len;
  logic [7:0]  byte0;
  logic [7:0]  byte1;
  logic [7:0]  byte2;
  logic [7:0]  byte3;
  logic [7:0]  byte4;
  logic [7:0]  byte5;
  logic        last;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = 2'd0;
  logic [15:0] wr_data = 16'd0;

  keypad_pin_collector_framer u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Requests waiting to be offered, and results the block still owes us.
  pad_req_t pad_requests[$];
  res_t     owed_results[$];

  // Our own copy of the block's PIN state and registers.
  cfg_t        regs = '{timeout_ms: 16'd5000, min_len: 4'd5, max_len: 4'd8};
  logic [7:0]  pin_chars[MAX_DIGITS];
  logic [3:0]  pin_len = 4'd0;
  logic [IDLE_W-1:0] idle_ms = '0;

  // Results produced by the request being predicted, in emission order.
  res_t result_batch[3];
  int   batch_n;

  int   err_cnt = 0;
  int   cycle_cnt = 0;
  bit   steady = 1'b0;      // no random idling on either side while set
  bit   stall_rx = 1'b0;    // receiver held off by the long stall process
  bit   holdoff_go = 1'b0;  // asks the stall process to start its stretch
  pad_req_t cur_req = '0;
  res_t     want;

  task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] exp_val);
    if (got !== exp_val) begin
      err_cnt++;
      if (err_cnt <= 40)
        $display("MISMATCH %s: got %0d, expected %0d at %0t", field, got, exp_val, $time);
    end
  endtask

  // Entry has completed: send "PIN:" plus the digits as frames when the PIN
  // is long enough, then clear it. At most two frames fit in a message.
  task automatic close_entry();
    logic [7:0] msg[PREFIX_LEN + MAX_DIGITS];
    res_t r;
    int   msg_len;
    int   nfr;
    int   nb;
    if (pin_len >= regs.min_len) begin
      msg[0] = "P";
      msg[1] = "I";
      msg[2] = "N";
      msg[3] = ":";
      for (int i = 0; i < int'(pin_len); i++)
        msg[PREFIX_LEN + i] = pin_chars[i];
      msg_len = PREFIX_LEN + int'(pin_len);
      nfr = (msg_len + FRAME_BYTES - 1) / FRAME_BYTES;
      for (int f = 0; f < nfr && f < 2; f++) begin
        nb = msg_len - f * FRAME_BYTES;
        if (nb > FRAME_BYTES)
          nb = FRAME_BYTES;
        r = '0;
        r.kind = KIND_FRAME;
        r.seq = 2'(f + 1);
        r.total = 2'(nfr);
        r.flen = 4'(nb + 2);
        for (int k = 0; k < nb; k++)
          r.bytes[k] = msg[f * FRAME_BYTES + k];
        result_batch[batch_n] = r;
        batch_n++;
      end
    end
    pin_len = 4'd0;
  endtask

  // Advances our PIN state by one accepted request and queues what it owes.
  task automatic apply_pad_request(pad_req_t rq);
    logic [7:0] ch;
    logic       done;
    res_t       beep;
    batch_n = 0;
    if (rq.act == ACT_TICK) begin
      // The idle count saturates, so once past the timeout every later
      // tick completes entry again until a key press clears it.
      if (idle_ms != IDLE_MAX)
        idle_ms = idle_ms + 1'b1;
      if (idle_ms > {1'b0, regs.timeout_ms})
        close_entry();
    end else if (rq.key < NUM_KEYS) begin
      done = 1'b0;
      if (rq.key == KEY_STAR) begin
        done = 1'b1;
      end else begin
        if (rq.key < 4'd9)
          ch = "1" + 8'(rq.key);
        else if (rq.key == 4'd10)
          ch = "0";
        else
          ch = "#";
        if (int'(pin_len) < MAX_DIGITS) begin
          pin_chars[pin_len] = ch;
          pin_len = pin_len + 4'd1;
        end
        // A full store completes entry even when max_len is larger.
        if (pin_len >= regs.max_len || int'(pin_len) >= MAX_DIGITS)
          done = 1'b1;
      end
      idle_ms = '0;
      if (done)
        close_entry();
      beep = '0;
      beep.kind = KIND_BEEP;
      result_batch[batch_n] = beep;
      batch_n++;
    end
    // Keys 12 to 15 leave everything untouched and owe nothing.
    if (batch_n > 0)
      result_batch[batch_n - 1].last = 1'b1;
    for (int i = 0; i < batch_n; i++)
      owed_results.push_back(result_batch[i]);
  endtask

  // Sender. A request is taken at an edge with push high and full low; the
  // next one goes out right away unless this cycle idles at random.
  always @(posedge clk) begin
    if (push && !full)
      apply_pad_request(cur_req);
    if (!push || !full) begin
      if (!rst && pad_requests.size() > 0 && (steady || $urandom_range(99) >= 25)) begin
        cur_req = pad_requests.pop_front();
        action <= cur_req.act;
        key_index <= cur_req.key;
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver. Every accepted result is matched against the oldest one owed.
  always @(posedge clk) begin
    if (pop && !empty) begin
      if (owed_results.size() == 0) begin
        report_mismatch("result with none outstanding", 8'd1, 8'd0);
      end else begin
        want = owed_results.pop_front();
        report_mismatch("kind", 8'(kind), 8'(want.kind));
        report_mismatch("seq", 8'(seq), 8'(want.seq));
        report_mismatch("total", 8'(total), 8'(want.total));
        report_mismatch("frame_len", 8'(frame_len), 8'(want.flen));
        report_mismatch("byte0", byte0, want.bytes[0]);
        report_mismatch("byte1", byte1, want.bytes[1]);
        report_mismatch("byte2", byte2, want.bytes[2]);
        report_mismatch("byte3", byte3, want.bytes[3]);
        report_mismatch("byte4", byte4, want.bytes[4]);
        report_mismatch("byte5", byte5, want.bytes[5]);
        report_mismatch("last", 8'(last), 8'(want.last));
      end
    end
    pop <= !rst && !stall_rx && (steady || $urandom_range(99) >= 25);
  end

  // Long receiver stall: the sender keeps offering requests, so the block's
  // command queue fills and full must hold the input back.
  initial begin
    wait (holdoff_go);
    @(posedge clk);
    stall_rx <= 1'b1;
    repeat (200) @(posedge clk);
    stall_rx <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Registers change only while the block is idle, so the predictor may
  // take the new values at once.
  task automatic set_regs(logic [15:0] tmo, logic [3:0] lo, logic [3:0] hi);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= REG_TIMEOUT;
    wr_data <= tmo;
    regs.timeout_ms = tmo;
    @(posedge clk);
    wr_index <= REG_MIN_LEN;
    wr_data <= {12'd0, lo};
    regs.min_len = lo;
    @(posedge clk);
    wr_index <= REG_MAX_LEN;
    wr_data <= {12'd0, hi};
    regs.max_len = hi;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic queue_key(logic [3:0] k);
    pad_requests.push_back('{act: ACT_KEY, key: k});
  endtask

  task automatic queue_tick(logic [3:0] k);
    pad_requests.push_back('{act: ACT_TICK, key: k});
  endtask

  // Waits until every request went in and every owed result came out, then
  // gives a tick that owes nothing time to finish inside the block.
  task automatic wait_drained();
    while (pad_requests.size() != 0 || push || owed_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random phase: mostly digits so that PINs reach the minimum and spill
  // into a second frame, some '*' presses, bursts of ticks long enough to
  // pass a small timeout, and a few unknown keys that do not count.
  task automatic queue_random(int quota, int tmo);
    int made;
    int r;
    int burst;
    int k;
    made = 0;
    while (made < quota) begin
      r = $urandom_range(99);
      if (r < 58) begin
        k = $urandom_range(10);
        if (k >= 9)
          k++;
        queue_key(4'(k));
        made++;
      end else if (r < 68) begin
        queue_key(KEY_STAR);
        made++;
      end else if (r < 90) begin
        burst = (tmo <= 8) ? $urandom_range(tmo + 2, 1) : $urandom_range(3, 1);
        for (int i = 0; i < burst; i++)
          queue_tick(4'($urandom_range(15)));
        made += burst;
      end else begin
        queue_key(4'($urandom_range(15, 12)));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Register defaults. Eight digits fill the store and send two full
    // frames; the ninth starts a new PIN. Unknown keys must be ignored, and
    // '*' on a three-digit PIN only beeps since the minimum is five.
    for (int k = 0; k < 9; k++)
      queue_key(4'(k));
    for (int k = 12; k < 16; k++)
      queue_key(4'(k));
    queue_key(4'd10);
    queue_key(4'd11);
    queue_key(KEY_STAR);
    wait_drained();

    // Maximum of zero completes on the first digit; with a minimum of zero
    // and a one-millisecond timeout, an empty PIN is sent as bare "PIN:" on
    // every tick past the timeout, and '*' on an empty PIN sends it too.
    set_regs(16'd1, 4'd0, 4'd0);
    queue_key(4'd4);
    queue_tick(4'd0);
    queue_tick(4'd15);
    queue_tick(4'd7);
    queue_key(KEY_STAR);
    wait_drained();

    // Random phases across the register ranges. The first one carries the
    // long receiver stall.
    set_regs(16'd3, 4'd2, 4'd8);
    queue_random(17, 3);
    holdoff_go = 1'b1;
    wait_drained();

    // Longest timeout and the largest reachable minimum, with no idling.
    set_regs(16'd65535, 4'd8, 4'd8);
    steady = 1'b1;
    queue_random(17, 65535);
    wait_drained();
    steady = 1'b0;

    // A minimum beyond the store means nothing is ever sent.
    set_regs(16'd2, 4'd15, 4'd4);
    queue_random(17, 2);
    wait_drained();

    // A maximum beyond the store: only a full store completes on digits.
    set_regs(16'd4, 4'd0, 4'd15);
    queue_random(17, 4);
    wait_drained();

    set_regs(16'd1, 4'd1, 4'd1);
    queue_random(17, 1);
    wait_drained();

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
